// ===== sv/fcte_pkg.sv =====
package fcte_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INACTIVE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX      = 2'd2;

   localparam logic       CMD_PACKET = 1'b0;
   localparam logic       CMD_FLUSH  = 1'b1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;
   localparam logic [7:0] FIN_RST    = 8'h05;

   localparam logic [31:0] ACTIVE_RST   = 32'd60000;
   localparam logic [31:0] INACTIVE_RST = 32'd10000;
   localparam logic [5:0]  MAX_RST      = 6'd32;

   typedef struct packed {
      logic        cmd;
      logic [31:0] timestamp_ms;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] l4_src;
      logic [15:0] l4_dst;
      logic [7:0]  protocol;
      logic [7:0]  tos;
      logic [15:0] ip_length;
      logic [7:0]  flag_byte;
   } fcte_req_type;

   typedef struct packed {
      logic [31:0] out_src_ip;
      logic [31:0] out_dst_ip;
      logic [15:0] out_l4_src;
      logic [15:0] out_l4_dst;
      logic [7:0]  out_protocol;
      logic [7:0]  out_tos;
      logic [7:0]  flags_seen;
      logic [31:0] packet_count;
      logic [31:0] octet_count;
      logic [31:0] first_ms;
      logic [31:0] last_ms;
      logic        last_of_run;
   } fcte_rsp_type;

   typedef struct packed {
      logic [31:0] active_timeout;
      logic [31:0] inactive_timeout;
      logic [5:0]  max_flows;
   } fcte_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOOT,
      ST_SWEEP,
      ST_DECIDE,
      ST_UPDATE,
      ST_CREATE,
      ST_EXPORT,
      ST_FLUSH,
      ST_DONE
   } fcte_state_type;

endpackage

// ===== sv/fcte_front.sv =====
module fcte_front import fcte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  fcte_req_type req_data,
   output logic         q_valid,
   output fcte_req_type q_data,
   input  logic         q_pop
);

   fcte_req_type slot_ff [2];
   fcte_req_type clean;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       wr_ff, wr_in;
   logic       push;

   // ports only mean something for TCP / UDP, flags only for TCP
   always_comb begin
      clean = req_data;
      if (req_data.protocol != PROTO_TCP && req_data.protocol != PROTO_UDP) begin
         clean.l4_src = '0;
         clean.l4_dst = '0;
      end
      if (req_data.protocol != PROTO_TCP) begin
         clean.flag_byte = '0;
      end
   end

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data  = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (q_pop) begin
         rd_in = ~rd_ff;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= clean;
      end
   end

endmodule

// ===== sv/fcte_back.sv =====
module fcte_back import fcte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  fcte_cfg_type cfg,
   input  logic         q_valid,
   input  fcte_req_type q_data,
   output logic         q_pop,
   output logic         rsp_valid,
   output fcte_rsp_type rsp_data
);

   fcte_state_type state_ff, state_in, ret_ff;

   fcte_req_type cur_ff;
   logic [31:0]      up_ff, boot_ff;
   logic             booted_ff;
   logic [CNT_W-1:0] pos_ff, live_ff;
   logic             found_ff;
   logic [IDX_W-1:0] tgt_ff;

   logic [CAPACITY-1:0] valid_ff;
   logic [IDX_W-1:0] age_ff   [CAPACITY];
   logic [31:0]      ksip_ff  [CAPACITY];
   logic [31:0]      kdip_ff  [CAPACITY];
   logic [31:0]      kport_ff [CAPACITY];
   logic [23:0]      ptf_ff   [CAPACITY];
   logic [31:0]      pkt_ff   [CAPACITY];
   logic [31:0]      byt_ff   [CAPACITY];
   logic [31:0]      st_ff    [CAPACITY];
   logic [31:0]      lt_ff    [CAPACITY];

   fcte_rsp_type pend_ff;
   logic         pend_v_ff;
   logic         rsp_valid_ff;
   fcte_rsp_type rsp_data_ff;
   fcte_rsp_type rsp_data_in;

   logic [IDX_W-1:0] rd_pos, slot, del_pos, free_idx;
   logic             free_ok, del_go, in_range, future, expire, match, fin;
   logic [CNT_W-1:0] lim;
   logic [31:0]      ports;
   fcte_rsp_type     ent;

   assign ports = {cur_ff.l4_src, cur_ff.l4_dst};
   assign fin   = |(cur_ff.flag_byte & FIN_RST);

   always_comb begin
      if (cfg.max_flows == '0) begin
         lim = CNT_W'(1);
      end else if (CNT_W'(cfg.max_flows) > CAP_CNT) begin
         lim = CAP_CNT;
      end else begin
         lim = CNT_W'(cfg.max_flows);
      end
   end

   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
            free_ok  = 1'b1;
         end
      end
   end

   // single read port into the flow table
   assign slot = age_ff[rd_pos];
   always_comb begin
      ent.out_src_ip   = ksip_ff[slot];
      ent.out_dst_ip   = kdip_ff[slot];
      ent.out_l4_src   = kport_ff[slot][31:16];
      ent.out_l4_dst   = kport_ff[slot][15:0];
      ent.out_protocol = ptf_ff[slot][23:16];
      ent.out_tos      = ptf_ff[slot][15:8];
      ent.flags_seen   = ptf_ff[slot][7:0];
      ent.packet_count = pkt_ff[slot];
      ent.octet_count  = byt_ff[slot];
      ent.first_ms     = st_ff[slot];
      ent.last_ms      = lt_ff[slot];
      ent.last_of_run  = 1'b0;
   end

   assign in_range = (pos_ff < live_ff);
   assign future   = (up_ff < ent.first_ms) || (up_ff < ent.last_ms);
   assign expire   = !future &&
                     (((up_ff - ent.first_ms) > cfg.active_timeout) ||
                      ((up_ff - ent.last_ms) > cfg.inactive_timeout));
   assign match    = (ent.out_src_ip == cur_ff.src_ip) &&
                     (ent.out_dst_ip == cur_ff.dst_ip) &&
                     (kport_ff[slot] == ports) &&
                     (ent.out_protocol == cur_ff.protocol);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_data.cmd == CMD_FLUSH) ? ST_FLUSH : ST_BOOT;
            end
         end
         ST_BOOT:   state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (!in_range) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (found_ff) begin
               state_in = ST_UPDATE;
            end else if (live_ff >= lim) begin
               state_in = ST_EXPORT;
            end else begin
               state_in = ST_CREATE;
            end
         end
         ST_UPDATE: state_in = fin ? ST_EXPORT : ST_DONE;
         ST_CREATE: state_in = (fin && free_ok && live_ff < CAP_CNT) ? ST_EXPORT : ST_DONE;
         ST_EXPORT: state_in = ret_ff;
         ST_FLUSH: begin
            if (live_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop   = 1'b0;
      rd_pos  = '0;
      del_go  = 1'b0;
      case (state_ff)
         ST_IDLE:   q_pop = q_valid;
         ST_SWEEP: begin
            rd_pos = pos_ff[IDX_W-1:0];
            del_go = in_range && expire;
         end
         ST_UPDATE: rd_pos = tgt_ff;
         ST_EXPORT: begin
            rd_pos = tgt_ff;
            del_go = 1'b1;
         end
         ST_FLUSH:  del_go = (live_ff != '0);
         default:   rd_pos = '0;
      endcase
   end
   assign del_pos = rd_pos;

   always_comb begin
      rsp_data_in             = pend_ff;
      rsp_data_in.last_of_run = (state_ff == ST_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_DONE;
         booted_ff    <= 1'b0;
         boot_ff      <= '0;
         live_ff      <= '0;
         valid_ff     <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= pend_v_ff && (del_go || state_ff == ST_DONE);
         if (del_go) begin
            pend_v_ff <= 1'b1;
         end else if (state_ff == ST_DONE) begin
            pend_v_ff <= 1'b0;
         end
         if (del_go) begin
            valid_ff[slot] <= 1'b0;
            live_ff        <= live_ff - CNT_W'(1);
         end
         case (state_ff)
            ST_BOOT: begin
               if (!booted_ff) begin
                  booted_ff <= 1'b1;
                  boot_ff   <= cur_ff.timestamp_ms;
               end
               pos_ff   <= '0;
               found_ff <= 1'b0;
            end
            ST_SWEEP: begin
               if (in_range && !expire) begin
                  pos_ff <= pos_ff + CNT_W'(1);
                  if (match) begin
                     found_ff <= 1'b1;
                  end
               end
            end
            ST_DECIDE: ret_ff <= ST_CREATE;
            ST_UPDATE: ret_ff <= ST_DONE;
            ST_CREATE: begin
               ret_ff <= ST_DONE;
               if (free_ok && live_ff < CAP_CNT) begin
                  valid_ff[free_idx] <= 1'b1;
                  live_ff            <= live_ff + CNT_W'(1);
               end
            end
            default: ret_ff <= ret_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid) begin
         cur_ff <= q_data;
      end
      if (state_ff == ST_BOOT) begin
         up_ff <= booted_ff ? (cur_ff.timestamp_ms - boot_ff) : '0;
      end
      if (state_ff == ST_SWEEP && in_range && !expire && match) begin
         tgt_ff <= pos_ff[IDX_W-1:0];
      end
      if (state_ff == ST_DECIDE && !found_ff) begin
         tgt_ff <= '0;
      end
      if (state_ff == ST_CREATE) begin
         tgt_ff <= live_ff[IDX_W-1:0];
      end
      if (del_go) begin
         pend_ff <= ent;
      end
      rsp_data_ff <= rsp_data_in;
      if (del_go) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IDX_W'(i) >= del_pos) begin
               age_ff[i] <= age_ff[i+1];
            end
         end
      end
      if (state_ff == ST_UPDATE) begin
         pkt_ff[slot] <= pkt_ff[slot] + 32'd1;
         byt_ff[slot] <= byt_ff[slot] + 32'(cur_ff.ip_length);
         lt_ff[slot]  <= up_ff;
         ptf_ff[slot] <= ptf_ff[slot] | 24'(cur_ff.flag_byte);
      end
      if (state_ff == ST_CREATE && free_ok && live_ff < CAP_CNT) begin
         ksip_ff[free_idx]  <= cur_ff.src_ip;
         kdip_ff[free_idx]  <= cur_ff.dst_ip;
         kport_ff[free_idx] <= ports;
         ptf_ff[free_idx]   <= {cur_ff.protocol, cur_ff.tos, cur_ff.flag_byte};
         pkt_ff[free_idx]   <= 32'd1;
         byt_ff[free_idx]   <= 32'(cur_ff.ip_length);
         st_ff[free_idx]    <= up_ff;
         lt_ff[free_idx]    <= up_ff;
         age_ff[live_ff[IDX_W-1:0]] <= free_idx;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/flow_cache_timeout_export.sv =====
// channel  | handshake      | payload
// request  | start / busy   | req_data  (fcte_req_type)
// result   | rsp_valid      | rsp_data  (fcte_rsp_type), one cycle each
// config   | csr_we         | csr_index, csr_wdata
//
// A packet's time in the back end grows with the number of live flows, set
// by the sweep over the flow table through its single read port, and grows
// for an eviction and for a FIN / RST export; a flush grows with live flows.
// A two-entry request queue lets the next request in while the back end
// works. Reset is synchronous; the table needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module flow_cache_timeout_export import fcte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fcte_req_type          req_data,
   output logic                  rsp_valid,
   output fcte_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   fcte_cfg_type cfg_ff;
   logic         q_valid, q_pop;
   fcte_req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_timeout   <= ACTIVE_RST;
         cfg_ff.inactive_timeout <= INACTIVE_RST;
         cfg_ff.max_flows        <= MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE:   cfg_ff.active_timeout   <= csr_wdata;
            CSR_INACTIVE: cfg_ff.inactive_timeout <= csr_wdata;
            CSR_MAX:      cfg_ff.max_flows        <= csr_wdata[5:0];
            default:      cfg_ff <= cfg_ff;
         endcase
      end
   end

   fcte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_pop    (q_pop)
   );

   fcte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
